### rtl/cst_pkg.sv
// Shared constants and types for the compacting slot table.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Default geometry
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Field widths fixed by the interface
    localparam int VALUE_PORT_WIDTH = 32;
    localparam int COUNT_PORT_WIDTH = 5;

    // Request codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Signals rippled from one cell to the next one up the chain
    typedef struct packed {
        logic hit;       // a slot at or below this point matched the remove value
        logic occupied;  // the slot just below holds an entry
    } chain_t;

endpackage

`default_nettype wire

### rtl/cst_cell.sv
// One slot of the table: holds an entry, matches, appends and shifts down.
`timescale 1ns / 1ps
`default_nettype none

module cst_cell #(
    parameter int ENTRY_WIDTH = cst_pkg::ENTRY_WIDTH_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     op_valid,
    input  wire                     op_remove,
    input  wire [ENTRY_WIDTH-1:0]   value,
    input  cst_pkg::chain_t         chain_in,
    output cst_pkg::chain_t         chain_out,
    input  wire [ENTRY_WIDTH-1:0]   upper_value,
    output logic [ENTRY_WIDTH-1:0]  slot_value
);

    logic [ENTRY_WIDTH-1:0] slot_reg;
    logic [ENTRY_WIDTH-1:0] slot_next;
    logic                   match;

    // Compare against the request and pass the chain upward
    assign match              = (slot_reg == value);
    assign chain_out.hit      = chain_in.hit | match;
    assign chain_out.occupied = (slot_reg != '0);
    assign slot_value         = slot_reg;

    // Append into the first empty slot, or take the upper neighbor past a removal
    always_comb
    begin
        slot_next = slot_reg;
        if (op_valid && !op_remove && (slot_reg == '0) && chain_in.occupied)
        begin
            slot_next = value;
        end
        else if (op_valid && op_remove && chain_out.hit)
        begin
            slot_next = upper_value;
        end
    end

    // Hold the slot; empty at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

### rtl/compacting_slot_table_top.sv
// Top level of the compacting slot table: request port, cell chain, result register.
//
// Usage:
//   Issue a request by raising start with req_type (add or remove) and
//   entry_value; it is taken at a rising edge where busy is low. busy is
//   always low, so one request can be taken every cycle.
//   The result (status, occupied_count) appears in the cycle after the request
//   is taken, marked by done for exactly one cycle. The receiver cannot
//   stall; results must be captured when done is high.
//   Throughput is one request per cycle: every slot cell compares and updates
//   in the same cycle, and the match and occupancy flags ripple through the
//   chain of SLOT_COUNT cells within that cycle.
//   An add stores the value in the first empty slot, or reports full. A
//   remove clears the first equal slot and shifts the later entries down one
//   place, keeping the table packed from slot 0.
//   Reset (rst_n low, asynchronous) empties every slot and clears done.
`timescale 1ns / 1ps
`default_nettype none

module compacting_slot_table_top #(
    parameter int SLOT_COUNT  = cst_pkg::SLOT_COUNT_DEF,
    parameter int ENTRY_WIDTH = cst_pkg::ENTRY_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire                                  req_type,
    input  wire [cst_pkg::VALUE_PORT_WIDTH-1:0]  entry_value,
    output logic                                 done,
    output logic                                 status,
    output logic [cst_pkg::COUNT_PORT_WIDTH-1:0] occupied_count
);

    localparam int CW = $clog2(SLOT_COUNT + 1);

    logic                   accept;
    logic                   op_remove;
    logic [ENTRY_WIDTH-1:0] value;
    logic                   full;
    logic                   value_nz;
    logic                   found;

    cst_pkg::chain_t        chain [SLOT_COUNT+1];
    logic [ENTRY_WIDTH-1:0] slot_q [SLOT_COUNT+1];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          status_reg;
    logic          status_next;

    // Take a transaction every cycle
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign op_remove = (req_type == cst_pkg::REQ_REMOVE);
    assign value     = ENTRY_WIDTH'(entry_value);
    assign value_nz  = (value != '0);
    assign full      = (count_reg == CW'(SLOT_COUNT));

    // Seed the chain: slot 0 always may take an append; nothing matched below it
    assign chain[0].hit      = 1'b0;
    assign chain[0].occupied = 1'b1;
    assign slot_q[SLOT_COUNT] = '0;

    // Build the row of slot cells
    for (genvar k = 0; k < SLOT_COUNT; k++)
    begin : g_cell
        cst_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op_valid    (accept),
            .op_remove   (op_remove),
            .value       (value),
            .chain_in    (chain[k]),
            .chain_out   (chain[k+1]),
            .upper_value (slot_q[k+1]),
            .slot_value  (slot_q[k])
        );
    end

    assign found = chain[SLOT_COUNT].hit;

    // Track the fill level alongside the packed table
    always_comb
    begin
        count_next  = count_reg;
        status_next = cst_pkg::STATUS_OK;
        if (accept)
        begin
            if (!op_remove)
            begin
                if (full)
                begin
                    status_next = cst_pkg::STATUS_FULL;
                end
                else if (value_nz)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            else if (found && value_nz)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    // Register the result and strobe done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= cst_pkg::STATUS_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign occupied_count = cst_pkg::COUNT_PORT_WIDTH'(count_reg);

    // Each taken request yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after request");

    // Full is reported only when every slot is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cst_pkg::STATUS_FULL) |-> (count_reg == CW'(SLOT_COUNT)))
        else $error("full reported on a table with free slots");

    // The fill level never exceeds the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOT_COUNT))
        else $error("fill level out of range");

    // The first slot past the fill level is always empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CW'(SLOT_COUNT)) |-> !chain[count_reg + CW'(1)].occupied)
        else $error("table not packed at fill level");

endmodule

`default_nettype wire
